// ===== sv/qrs_pkg.sv =====
package qrs_pkg;

    // Coefficient and fraction widths of the datapath.
    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int ROOT_BITS = 34;

    // Signed discriminant b*b - 4ac, and its even-width magnitude register.
    localparam int PROD_W   = 2 * COEF_BITS + 2;
    localparam int D_W      = 2 * COEF_BITS + 2;
    // One square root digit per cell: integer pairs, then fraction pairs.
    localparam int SQ_STEPS = D_W / 2 + FRAC_BITS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int REM_W    = ROOT_W + 3;
    // Numerator magnitude, divisor magnitude |2a| and divider remainder.
    localparam int NUM_W    = COEF_BITS + FRAC_BITS + 2;
    localparam int DEN_W    = COEF_BITS + 1;
    localparam int DREM_W   = DEN_W + 1;

    typedef enum logic [1:0] {
        ST_REAL    = 2'd0,
        ST_COMPLEX = 2'd1,
        ST_A_ZERO  = 2'd2
    } status_t;

    typedef struct packed {
        logic [D_W-1:0]    d;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [NUM_W-1:0]  n;
        logic [DREM_W-1:0] rem;
        logic [NUM_W-1:0]  q;
        logic [DEN_W-1:0]  den;
    } div_t;

    typedef struct packed {
        logic                        valid;
        status_t                     status;
        logic signed [COEF_BITS-1:0] a;
        logic signed [COEF_BITS-1:0] b;
    } sq_side_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        logic    neg_p;
        logic    neg_m;
    } div_side_t;

endpackage

// ===== sv/qrs_sqrt_cell.sv =====
// One digit of the square root: takes the next bit pair of the radicand.
module qrs_sqrt_cell import qrs_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  sq_t  in_s,
    output sq_t  out_s
);

    sq_t              cell_reg;
    sq_t              cell_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb begin
        rem_sh = {in_s.rem[REM_W-3:0], in_s.d[D_W-1 -: 2]};
        trial  = REM_W'({in_s.root, 2'b01});
        cell_next.d = {in_s.d[D_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {in_s.root[ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_sh;
            cell_next.root = {in_s.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_s = cell_reg;

endmodule

// ===== sv/qrs_div_cell.sv =====
// One quotient bit of a restoring divider on unsigned magnitudes.
module qrs_div_cell import qrs_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  div_t in_d,
    output div_t out_d
);

    div_t              cell_reg;
    div_t              cell_next;
    logic [DREM_W-1:0] rem_sh;
    logic [DREM_W-1:0] den_w;

    always_comb begin
        rem_sh = {in_d.rem[DREM_W-2:0], in_d.n[NUM_W-1]};
        den_w  = {1'b0, in_d.den};
        cell_next.n   = {in_d.n[NUM_W-2:0], 1'b0};
        cell_next.den = in_d.den;
        if (rem_sh >= den_w) begin
            cell_next.rem = rem_sh - den_w;
            cell_next.q   = {in_d.q[NUM_W-2:0], 1'b1};
        end else begin
            cell_next.rem = rem_sh;
            cell_next.q   = {in_d.q[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_d = cell_reg;

endmodule

// ===== sv/quadratic_root_solver.sv =====
// Real roots of a*x^2 + b*x + c for signed 16-bit integer coefficients. Each
// transaction on the s_ channel carries one coefficient set; the m_ channel
// returns one transaction per set, in order: both roots (-b +/- s)/(2a) in
// signed Q17.16, truncated toward zero, where s is the square root of the
// exact discriminant b*b - 4ac floored to 16 fraction bits. root_status is 0
// for real roots, 1 when the discriminant is negative, 2 when a is zero; in
// the last two cases both roots read zero. The datapath is a chain of cells
// that all advance together: a product stage and a discriminant stage, 33
// square root cells (one result bit each), a numerator stage, 34 divider cells
// (one quotient bit each, both roots side by side) and the output register.
// One transaction is accepted every cycle; the whole chain holds only while a
// finished result waits in the output register and m_ready is low.
module quadratic_root_solver import qrs_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COEF_BITS-1:0] s_coef_a,
    input  logic signed [COEF_BITS-1:0] s_coef_b,
    input  logic signed [COEF_BITS-1:0] s_coef_c,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [ROOT_BITS-1:0] m_root_plus,
    output logic signed [ROOT_BITS-1:0] m_root_minus,
    output logic [1:0]                  m_root_status
);

    // The chain moves whenever the output register is empty or being drained.
    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Product stage: b*b and a*c, each a single signed multiplier.
    logic                          v1_reg;
    logic signed [COEF_BITS-1:0]   a1_reg;
    logic signed [COEF_BITS-1:0]   b1_reg;
    logic signed [2*COEF_BITS-1:0] bb_reg;
    logic signed [2*COEF_BITS-1:0] ac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= s_coef_a;
            b1_reg <= s_coef_b;
            bb_reg <= s_coef_b * s_coef_b;
            ac_reg <= s_coef_a * s_coef_c;
        end
    end

    // Discriminant stage: exact b*b - 4ac, then the status is settled here.
    logic signed [PROD_W-1:0] disc;
    sq_side_t                 side0_next;
    sq_t                      sq0_next;

    always_comb begin
        disc = PROD_W'(bb_reg) - (PROD_W'(ac_reg) <<< 2);
        side0_next.valid = v1_reg;
        side0_next.a     = a1_reg;
        side0_next.b     = b1_reg;
        if (a1_reg == '0) begin
            side0_next.status = ST_A_ZERO;
        end else if (disc < 0) begin
            side0_next.status = ST_COMPLEX;
        end else begin
            side0_next.status = ST_REAL;
        end
        sq0_next.d    = D_W'(disc);
        sq0_next.rem  = '0;
        sq0_next.root = '0;
    end

    // Square root chain: stage k of sq_pipe feeds cell k.
    sq_t      sq_pipe  [0:SQ_STEPS];
    sq_side_t side_reg [0:SQ_STEPS];
    sq_t      sq0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq0_reg <= sq0_next;
        end
    end

    assign sq_pipe[0] = sq0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= SQ_STEPS; k++) begin
                side_reg[k] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= side0_next;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .in_s  (sq_pipe[k]),
            .out_s (sq_pipe[k+1])
        );
    end

    // Numerator stage: -b scaled by the fraction, plus and minus the root,
    // split into magnitudes and quotient signs for the unsigned dividers.
    sq_side_t              sq_last;
    logic signed [NUM_W:0] nb;
    logic signed [NUM_W:0] num_p;
    logic signed [NUM_W:0] num_m;
    logic signed [NUM_W:0] root_w;
    logic [DEN_W-1:0]      a_w;
    logic [DEN_W-1:0]      a_abs;
    logic                  a_neg;
    div_t                  dp0_next;
    div_t                  dm0_next;
    div_side_t             dside0_next;

    always_comb begin
        sq_last = side_reg[SQ_STEPS];
        root_w  = $signed((NUM_W+1)'(sq_pipe[SQ_STEPS].root));
        nb      = -((NUM_W+1)'(sq_last.b) <<< FRAC_BITS);
        num_p   = nb + root_w;
        num_m   = nb - root_w;
        a_neg   = sq_last.a[COEF_BITS-1];
        a_w     = DEN_W'(sq_last.a);
        a_abs   = a_neg ? (DEN_W)'(-a_w) : a_w;

        dp0_next.n   = num_p[NUM_W] ? NUM_W'(-num_p) : NUM_W'(num_p);
        dp0_next.rem = '0;
        dp0_next.q   = '0;
        dp0_next.den = {a_abs[DEN_W-2:0], 1'b0};
        dm0_next.n   = num_m[NUM_W] ? NUM_W'(-num_m) : NUM_W'(num_m);
        dm0_next.rem = '0;
        dm0_next.q   = '0;
        dm0_next.den = {a_abs[DEN_W-2:0], 1'b0};

        dside0_next.valid  = sq_last.valid;
        dside0_next.status = sq_last.status;
        dside0_next.neg_p  = num_p[NUM_W] ^ a_neg;
        dside0_next.neg_m  = num_m[NUM_W] ^ a_neg;
    end

    // Divider chains, one lane per root.
    div_t      dp_pipe   [0:NUM_W];
    div_t      dm_pipe   [0:NUM_W];
    div_side_t dside_reg [0:NUM_W];
    div_t      dp0_reg;
    div_t      dm0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dp0_reg <= dp0_next;
            dm0_reg <= dm0_next;
        end
    end

    assign dp_pipe[0] = dp0_reg;
    assign dm_pipe[0] = dm0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NUM_W; k++) begin
                dside_reg[k] <= '0;
            end
        end else if (en) begin
            dside_reg[0] <= dside0_next;
            for (int k = 1; k <= NUM_W; k++) begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        qrs_div_cell u_cell_p (
            .aclk  (aclk),
            .en    (en),
            .in_d  (dp_pipe[k]),
            .out_d (dp_pipe[k+1])
        );
        qrs_div_cell u_cell_m (
            .aclk  (aclk),
            .en    (en),
            .in_d  (dm_pipe[k]),
            .out_d (dm_pipe[k+1])
        );
    end

    // Output register: restore the quotient signs and zero the roots unless
    // they are real.
    div_side_t                    d_last;
    logic signed [NUM_W:0]        qp_s;
    logic signed [NUM_W:0]        qm_s;
    logic signed [ROOT_BITS-1:0]  root_p_reg;
    logic signed [ROOT_BITS-1:0]  root_p_next;
    logic signed [ROOT_BITS-1:0]  root_m_reg;
    logic signed [ROOT_BITS-1:0]  root_m_next;
    status_t                      status_reg;

    always_comb begin
        d_last = dside_reg[NUM_W];
        qp_s   = $signed({1'b0, dp_pipe[NUM_W].q});
        qm_s   = $signed({1'b0, dm_pipe[NUM_W].q});
        if (d_last.neg_p) begin
            qp_s = -qp_s;
        end
        if (d_last.neg_m) begin
            qm_s = -qm_s;
        end
        if (d_last.status == ST_REAL) begin
            root_p_next = ROOT_BITS'(qp_s);
            root_m_next = ROOT_BITS'(qm_s);
        end else begin
            root_p_next = '0;
            root_m_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_p_reg <= root_p_next;
            root_m_reg <= root_m_next;
            status_reg <= d_last.status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_root_plus   = root_p_reg;
    assign m_root_minus  = root_m_reg;
    assign m_root_status = status_reg;

endmodule

// ===== sv/qrs_checker.sv =====
// Port-level checks for the root solver.
module qrs_checker import qrs_pkg::*; (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [ROOT_BITS-1:0] m_root_plus,
    input logic signed [ROOT_BITS-1:0] m_root_minus,
    input logic [1:0]                  m_root_status
);

    // A result that waits keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root_plus)
            && $stable(m_root_minus) && $stable(m_root_status))
        else $error("result changed while stalled");

    // Complex roots and a zero leading coefficient give zero roots.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_status != ST_REAL |-> m_root_plus == '0 && m_root_minus == '0)
        else $error("nonzero root with non-real status");

    // Input is taken exactly when the output register can move.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow the output stall");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // No result is valid right after reset is released.
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !aresetn || !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking regression for the quadratic root solver. Coefficient sets are
// sent on the s_ channel, the expected roots are predicted in the testbench,
// and every m_ transaction is compared with the oldest prediction.
module testbench;
    import qrs_pkg::*;

    // Latency of the pipeline, used with a margin for the final drain.
    localparam int LATENCY = 71;

    typedef struct packed {
        logic signed [ROOT_BITS-1:0] plus;
        logic signed [ROOT_BITS-1:0] minus;
        status_t                     status;
    } roots_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [COEF_BITS-1:0] s_coef_a = '0;
    logic signed [COEF_BITS-1:0] s_coef_b = '0;
    logic signed [COEF_BITS-1:0] s_coef_c = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [ROOT_BITS-1:0] m_root_plus;
    logic signed [ROOT_BITS-1:0] m_root_minus;
    logic [1:0]                  m_root_status;

    // Idle percentages for each side; changed between phases.
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     error_count = 0;
    roots_t pending_roots[$];

    always #1 aclk = ~aclk;

    quadratic_root_solver u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_coef_a     (s_coef_a),
        .s_coef_b     (s_coef_b),
        .s_coef_c     (s_coef_c),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_root_plus  (m_root_plus),
        .m_root_minus (m_root_minus),
        .m_root_status(m_root_status)
    );

    // Floor of sqrt(d) scaled by 2^FRAC_BITS, one result bit per pair of bits.
    function automatic logic [63:0] scaled_isqrt(logic [63:0] d);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        logic [63:0] pair;
        root = '0;
        rem = '0;
        for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
            pair = (i >= FRAC_BITS) ? ((d >> (2 * (i - FRAC_BITS))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Predicted roots of one coefficient set. SystemVerilog division on signed
    // operands truncates toward zero, which is the rounding the block uses.
    function automatic roots_t solve_roots(logic signed [COEF_BITS-1:0] a,
                                           logic signed [COEF_BITS-1:0] b,
                                           logic signed [COEF_BITS-1:0] c);
        roots_t      r;
        longint      disc;
        longint      nb;
        longint      den;
        longint      s;
        longint      qp;
        longint      qm;
        r = '0;
        if (a == 0) begin
            r.status = ST_A_ZERO;
            return r;
        end
        disc = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
        if (disc < 0) begin
            r.status = ST_COMPLEX;
            return r;
        end
        s = longint'(scaled_isqrt(disc));
        nb = -longint'(b) * (longint'(1) << FRAC_BITS);
        den = 2 * longint'(a);
        qp = (nb + s) / den;
        qm = (nb - s) / den;
        r.plus = qp[ROOT_BITS-1:0];
        r.minus = qm[ROOT_BITS-1:0];
        r.status = ST_REAL;
        return r;
    endfunction

    // Send one coefficient set, with a random idle gap before it. Valid stays
    // high across back-to-back transactions without being dropped.
    task automatic send_coefs(logic signed [COEF_BITS-1:0] a,
                              logic signed [COEF_BITS-1:0] b,
                              logic signed [COEF_BITS-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        pending_roots.push_back(solve_roots(a, b, c));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every predicted result has been returned.
    task automatic wait_drained();
        while (pending_roots.size() != 0) @(posedge aclk);
    endtask

    // Random receiver stalls, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Checker: each accepted m_ transaction against the oldest prediction.
    always @(posedge aclk) begin
        roots_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result plus=%0d minus=%0d status=%0d",
                         $time, m_root_plus, m_root_minus, m_root_status);
                error_count++;
            end else begin
                want = pending_roots.pop_front();
                if (m_root_plus !== want.plus) begin
                    $display("%0t: root_plus expected %0d actual %0d",
                             $time, want.plus, m_root_plus);
                    error_count++;
                end
                if (m_root_minus !== want.minus) begin
                    $display("%0t: root_minus expected %0d actual %0d",
                             $time, want.minus, m_root_minus);
                    error_count++;
                end
                if (m_root_status !== want.status) begin
                    $display("%0t: root_status expected %0d actual %0d",
                             $time, want.status, m_root_status);
                    error_count++;
                end
            end
        end
    end

    // Directed sets: field extremes, a zero, both signs, perfect squares,
    // a zero discriminant and a negative one.
    task automatic test_directed();
        send_coefs(16'sd0, 16'sd5, 16'sd3);
        send_coefs(16'sd0, -16'sd32768, 16'sd32767);
        send_coefs(16'sd1, 16'sd0, 16'sd1);
        send_coefs(16'sd1, -16'sd3, 16'sd2);
        send_coefs(16'sd1, 16'sd2, 16'sd1);
        send_coefs(-16'sd1, 16'sd0, 16'sd4);
        send_coefs(16'sd1, 16'sd0, 16'sd0);
        send_coefs(16'sd1, 16'sd0, -16'sd2);
        send_coefs(16'sd32767, 16'sd32767, 16'sd32767);
        send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
        send_coefs(-16'sd32768, -16'sd32768, 16'sd32767);
        send_coefs(16'sd32767, -16'sd32768, -16'sd32768);
        send_coefs(16'sd1, -16'sd32768, -16'sd32768);
        send_coefs(-16'sd1, 16'sd32767, 16'sd32767);
        send_coefs(16'sd1, 16'sd32767, 16'sd0);
        send_coefs(16'sd1, -16'sd32768, 16'sd0);
        send_coefs(-16'sd32768, 16'sd0, 16'sd32767);
        send_coefs(16'sd3, 16'sd1, -16'sd5);
        send_coefs(-16'sd7, 16'sd1, 16'sd9);
        send_coefs(16'sd2, 16'sd1, 16'sd1);
        stop_sending();
    endtask

    // Random sets. Some draw small a and c so real roots are common; most
    // use full-range values and some force a zero leading coefficient.
    task automatic test_random(int count);
        logic signed [COEF_BITS-1:0] a;
        logic signed [COEF_BITS-1:0] b;
        logic signed [COEF_BITS-1:0] c;
        for (int i = 0; i < count; i++) begin
            a = COEF_BITS'($urandom);
            b = COEF_BITS'($urandom);
            c = COEF_BITS'($urandom);
            case ($urandom_range(9))
                0: a = '0;
                1, 2, 3: begin
                    a = COEF_BITS'($signed($urandom_range(255)) - 128);
                    c = COEF_BITS'($signed($urandom_range(255)) - 128);
                end
                4: c = -c ^ a;
                default: ;
            endcase
            send_coefs(a, b, c);
        end
        stop_sending();
    endtask

    // The sender holds off until the pipeline is empty, then resumes.
    task automatic test_hold_off();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 26;
        recv_idle_pct = 83;
        test_directed();
        test_random(330);

        send_idle_pct = 83;
        recv_idle_pct = 26;
        test_hold_off();
        test_random(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(340);

        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0 && pending_roots.size() == 0) begin
            $display("quadratic_root_solver regression: pass");
        end else begin
            $display("quadratic_root_solver regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("quadratic_root_solver regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/qrs_pkg.sv
sv/qrs_sqrt_cell.sv
sv/qrs_div_cell.sv
sv/quadratic_root_solver.sv
sv/qrs_checker.sv
sim/testbench.sv
